// ===== design/kce_pkg.sv =====
// shared constants for the keypad calculator entry block
package kce_pkg;

  localparam int KEY_WIDTH   = 8;
  localparam int OUT_WIDTH   = 32;
  localparam int FIELD_WIDTH = 2;
  localparam int OP_WIDTH    = 2;

  // key codes
  localparam logic [KEY_WIDTH-1:0] KEY_NONE     = 8'h00;
  localparam logic [KEY_WIDTH-1:0] KEY_BACK     = 8'h08;
  localparam logic [KEY_WIDTH-1:0] KEY_UP       = 8'h18;
  localparam logic [KEY_WIDTH-1:0] KEY_DOWN     = 8'h19;
  localparam logic [KEY_WIDTH-1:0] KEY_RIGHT    = 8'h1a;
  localparam logic [KEY_WIDTH-1:0] KEY_LEFT     = 8'h1b;
  localparam logic [KEY_WIDTH-1:0] KEY_DIGIT_LO = 8'h30;
  localparam logic [KEY_WIDTH-1:0] KEY_DIGIT_HI = 8'h39;

  // selected field
  localparam logic [FIELD_WIDTH-1:0] FIELD_FIRST  = 2'd0;
  localparam logic [FIELD_WIDTH-1:0] FIELD_OP     = 2'd1;
  localparam logic [FIELD_WIDTH-1:0] FIELD_SECOND = 2'd2;

  // operators
  localparam logic [OP_WIDTH-1:0] OP_ADD = 2'd0;
  localparam logic [OP_WIDTH-1:0] OP_SUB = 2'd1;
  localparam logic [OP_WIDTH-1:0] OP_MUL = 2'd2;
  localparam logic [OP_WIDTH-1:0] OP_DIV = 2'd3;

  localparam int DECIMAL_BASE = 10;

endpackage

// ===== design/kce_key_if.sv =====
// key input channel
interface kce_key_if;
  import kce_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [KEY_WIDTH-1:0] key_code;

  modport source (output valid, output key_code, input ready);
  modport sink (input valid, input key_code, output ready);
endinterface

// ===== design/kce_result_if.sv =====
// result output channel
interface kce_result_if;
  import kce_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [OUT_WIDTH-1:0]   first_value;
  logic signed [OUT_WIDTH-1:0]   second_value;
  logic        [OP_WIDTH-1:0]    op_select;
  logic        [FIELD_WIDTH-1:0] field_select;
  logic signed [OUT_WIDTH-1:0]   result_value;

  modport source (
    output valid, output first_value, output second_value, output op_select,
    output field_select, output result_value, input ready
  );
  modport sink (
    input valid, input first_value, input second_value, input op_select,
    input field_select, input result_value, output ready
  );
endinterface

// ===== design/keypad_calculator_entry.sv =====
// keypad calculator entry: key decode, operand editing and bit-serial mul/div
//
// Usage: one key code enters on the key channel per transfer; every key gives
// exactly one transfer on the result channel carrying both operands, the
// operator, the selected field and first-op-second (low bits, wrapping).
// Values are DATA_WIDTH bits wide; the 32-bit output fields carry the low
// bits, zero-extended when DATA_WIDTH is below 32.
// Flow: a key that needs only add/sub arithmetic goes from idle through the
// prepare state to finish. A backspace (divide by ten) first runs the shared
// shift-and-add / restoring-divide unit and writes the quotient back to the
// operand, and a multiply or divide result runs the unit again, one quotient
// or product bit per cycle.
// One key is in work at a time; key.ready is high while the block is idle,
// and a key can be taken while the previous result still waits.
// Reset clears both operands, the operator (add) and the selection (first
// operand), and drops any pending result. When the receiver stalls the
// result is held in the output register and the next key finishes its work
// and then waits until that register is free.
module keypad_calculator_entry #(
  parameter int DATA_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  kce_key_if.sink       key,
  kce_result_if.source  result
);
  import kce_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int CW = $clog2(W + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_RUN,
    S_TAKE,
    S_FINISH
  } state_t;

  state_t                 state;
  logic [W-1:0]           first_op;
  logic [W-1:0]           second_op;
  logic [OP_WIDTH-1:0]    op_sel;
  logic [FIELD_WIDTH-1:0] field_sel;
  logic [W-1:0]           res;

  // shared serial unit
  logic [W-1:0]  ua;
  logic [W-1:0]  ub;
  logic [W-1:0]  rem;
  logic [CW-1:0] cnt;
  logic          is_div;
  logic          neg;
  logic          to_edit;

  // output register
  logic                   out_valid;
  logic [W-1:0]           out_first;
  logic [W-1:0]           out_second;
  logic [OP_WIDTH-1:0]    out_op;
  logic [FIELD_WIDTH-1:0] out_field;
  logic [W-1:0]           out_res;

  logic                   key_xfer;
  logic                   is_digit;
  logic [3:0]             digit;
  logic [W-1:0]           cur_val;
  logic [W-1:0]           edit_val;
  logic                   start_back;
  logic [FIELD_WIDTH-1:0] field_sel_next;
  logic [OP_WIDTH-1:0]    op_sel_next;
  logic                   edit_wr;

  logic [W:0]   trial;
  logic [W:0]   diff;
  logic [W-1:0] take_val;

  assign key_xfer = key.valid && key.ready;
  assign key.ready = (state == S_IDLE);

  assign is_digit = (key.key_code >= KEY_DIGIT_LO) && (key.key_code <= KEY_DIGIT_HI);
  assign digit    = 4'(key.key_code - KEY_DIGIT_LO);
  assign cur_val  = (field_sel == FIELD_FIRST) ? first_op : second_op;

  // key decode
  always_comb begin
    field_sel_next = field_sel;
    op_sel_next    = op_sel;
    edit_val       = cur_val;
    edit_wr        = 1'b0;
    start_back     = 1'b0;
    if (key.key_code == KEY_UP) begin
      if (field_sel != FIELD_FIRST) field_sel_next = field_sel - 1'b1;
    end else if (key.key_code == KEY_DOWN) begin
      if (field_sel != FIELD_SECOND) field_sel_next = field_sel + 1'b1;
    end else if (key.key_code != KEY_NONE) begin
      if (field_sel == FIELD_OP) begin
        if (key.key_code == KEY_LEFT && op_sel != OP_ADD) begin
          op_sel_next = op_sel - 1'b1;
        end else if (key.key_code == KEY_RIGHT && op_sel != OP_DIV) begin
          op_sel_next = op_sel + 1'b1;
        end
      end else begin
        if (is_digit) begin
          edit_val = (cur_val << 3) + (cur_val << 1) + W'(digit);
          edit_wr  = 1'b1;
        end else if (key.key_code == KEY_LEFT || key.key_code == KEY_RIGHT) begin
          edit_val = -cur_val;
          edit_wr  = 1'b1;
        end else if (key.key_code == KEY_BACK) begin
          start_back = 1'b1;
        end
      end
    end
  end

  // one restoring-divide step: remainder shifts in the next dividend bit
  assign trial = {rem, ua[W-1]};
  assign diff  = trial - {1'b0, ub};

  assign take_val = is_div ? (neg ? -ua : ua) : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      first_op  <= '0;
      second_op <= '0;
      op_sel    <= OP_ADD;
      field_sel <= FIELD_FIRST;
      out_valid <= 1'b0;
    end else begin
      // finish reloads the output register itself
      if (result.ready && state != S_FINISH) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (key_xfer) begin
            field_sel <= field_sel_next;
            op_sel    <= op_sel_next;
            if (edit_wr) begin
              if (field_sel == FIELD_FIRST) first_op <= edit_val;
              else second_op <= edit_val;
            end
            if (start_back) begin
              // backspace: truncating divide by ten on magnitudes
              ua      <= cur_val[W-1] ? -cur_val : cur_val;
              ub      <= W'(DECIMAL_BASE);
              rem     <= '0;
              neg     <= cur_val[W-1];
              is_div  <= 1'b1;
              to_edit <= 1'b1;
              cnt     <= '0;
              state   <= S_RUN;
            end else begin
              state <= S_PREP;
            end
          end
        end
        S_PREP: begin
          to_edit <= 1'b0;
          rem     <= '0;
          cnt     <= '0;
          case (op_sel)
            OP_ADD: begin
              res   <= first_op + second_op;
              state <= S_FINISH;
            end
            OP_SUB: begin
              res   <= first_op - second_op;
              state <= S_FINISH;
            end
            OP_MUL: begin
              ua     <= first_op;
              ub     <= second_op;
              is_div <= 1'b0;
              state  <= S_RUN;
            end
            default: begin
              if (second_op == '0) begin
                res   <= '0;
                state <= S_FINISH;
              end else begin
                ua     <= first_op[W-1] ? -first_op : first_op;
                ub     <= second_op[W-1] ? -second_op : second_op;
                neg    <= first_op[W-1] ^ second_op[W-1];
                is_div <= 1'b1;
                state  <= S_RUN;
              end
            end
          endcase
        end
        S_RUN: begin
          if (is_div) begin
            if (!diff[W]) begin
              rem <= diff[W-1:0];
              ua  <= {ua[W-2:0], 1'b1};
            end else begin
              rem <= trial[W-1:0];
              ua  <= {ua[W-2:0], 1'b0};
            end
          end else begin
            // low bits of the product only, lsb of the multiplier first
            if (ub[0]) rem <= rem + ua;
            ua <= ua << 1;
            ub <= ub >> 1;
          end
          cnt <= cnt + 1'b1;
          if (cnt == CW'(W - 1)) state <= S_TAKE;
        end
        S_TAKE: begin
          if (to_edit) begin
            if (field_sel == FIELD_FIRST) first_op <= take_val;
            else second_op <= take_val;
            state <= S_PREP;
          end else begin
            res   <= take_val;
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!out_valid || result.ready) begin
            out_valid  <= 1'b1;
            out_first  <= first_op;
            out_second <= second_op;
            out_op     <= op_sel;
            out_field  <= field_sel;
            out_res    <= res;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid        = out_valid;
  assign result.first_value  = OUT_WIDTH'(out_first);
  assign result.second_value = OUT_WIDTH'(out_second);
  assign result.op_select    = out_op;
  assign result.field_select = out_field;
  assign result.result_value = OUT_WIDTH'(out_res);

`ifndef SYNTHESIS
  a_field_range: assert property (@(posedge clk) disable iff (rst)
    field_sel != 2'd3)
    else $error("selected field out of range");

  a_run_count: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> cnt < CW'(W))
    else $error("serial unit ran past its last step");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    key_xfer |=> state != S_IDLE)
    else $error("key transfer did not start work");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FINISH)
    else $error("result appeared outside finish");

  a_edit_only_operand: assert property (@(posedge clk) disable iff (rst)
    state == S_TAKE && to_edit |-> field_sel != FIELD_OP)
    else $error("backspace divide aimed at the operator field");
`endif

endmodule

// ===== tb/sv/kce_checker.sv =====
// watches the key and result channels, predicts each result and compares it
`timescale 1ns / 100ps

module kce_checker (
  input  logic  clk,
  input  logic  rst,
  kce_key_if    key_mon,
  kce_result_if res_mon,
  output int    fail_count,
  output int    pending_results
);
  import kce_pkg::*;

  typedef struct {
    logic signed [OUT_WIDTH-1:0]   first_value;
    logic signed [OUT_WIDTH-1:0]   second_value;
    logic        [OP_WIDTH-1:0]    op_select;
    logic        [FIELD_WIDTH-1:0] field_select;
    logic signed [OUT_WIDTH-1:0]   result_value;
  } calc_view_t;

  logic [OUT_WIDTH-1:0]   first_acc;
  logic [OUT_WIDTH-1:0]   second_acc;
  logic [OP_WIDTH-1:0]    cur_op;
  logic [FIELD_WIDTH-1:0] cur_field;
  calc_view_t             expected_views[$];
  int                     results_seen;

  // signed divide truncating toward zero; zero divisor gives zero
  function automatic logic [OUT_WIDTH-1:0] div_trunc(
    input logic [OUT_WIDTH-1:0] num,
    input logic [OUT_WIDTH-1:0] den
  );
    logic [OUT_WIDTH-1:0] mag_num;
    logic [OUT_WIDTH-1:0] mag_den;
    logic [OUT_WIDTH-1:0] quo;
    if (den == '0) return '0;
    mag_num = num[OUT_WIDTH-1] ? -num : num;
    mag_den = den[OUT_WIDTH-1] ? -den : den;
    quo     = mag_num / mag_den;
    return (num[OUT_WIDTH-1] ^ den[OUT_WIDTH-1]) ? -quo : quo;
  endfunction

  function automatic logic [OUT_WIDTH-1:0] edit_operand(
    input logic [OUT_WIDTH-1:0] val,
    input logic [KEY_WIDTH-1:0] k
  );
    logic [OUT_WIDTH-1:0] digit;
    digit = OUT_WIDTH'(k - KEY_DIGIT_LO);
    if (k >= KEY_DIGIT_LO && k <= KEY_DIGIT_HI)
      return val * OUT_WIDTH'(DECIMAL_BASE) + digit;
    if (k == KEY_RIGHT || k == KEY_LEFT) return -val;
    if (k == KEY_BACK) return div_trunc(val, OUT_WIDTH'(DECIMAL_BASE));
    return val;
  endfunction

  function automatic logic [OUT_WIDTH-1:0] combine(
    input logic [OUT_WIDTH-1:0] a,
    input logic [OUT_WIDTH-1:0] b,
    input logic [OP_WIDTH-1:0]  op
  );
    case (op)
      OP_ADD:  return a + b;
      OP_SUB:  return a - b;
      OP_MUL:  return a * b;
      default: return div_trunc(a, b);
    endcase
  endfunction

  task automatic apply_key(input logic [KEY_WIDTH-1:0] k);
    calc_view_t view;
    if (k == KEY_UP) begin
      if (cur_field != FIELD_FIRST) cur_field = cur_field - 1'b1;
    end else if (k == KEY_DOWN) begin
      if (cur_field != FIELD_SECOND) cur_field = cur_field + 1'b1;
    end else if (k != KEY_NONE) begin
      if (cur_field == FIELD_FIRST) begin
        first_acc = edit_operand(first_acc, k);
      end else if (cur_field == FIELD_SECOND) begin
        second_acc = edit_operand(second_acc, k);
      end else if (k == KEY_LEFT && cur_op != OP_ADD) begin
        cur_op = cur_op - 1'b1;
      end else if (k == KEY_RIGHT && cur_op != OP_DIV) begin
        cur_op = cur_op + 1'b1;
      end
    end
    view.first_value  = first_acc;
    view.second_value = second_acc;
    view.op_select    = cur_op;
    view.field_select = cur_field;
    view.result_value = combine(first_acc, second_acc, cur_op);
    expected_views.push_back(view);
  endtask

  task automatic report_mismatch(
    input string                       field_name,
    input logic signed [OUT_WIDTH-1:0] want,
    input logic signed [OUT_WIDTH-1:0] got
  );
    $display("result %0d: %s mismatch, expected %0d got %0d",
             results_seen, field_name, want, got);
    fail_count++;
  endtask

  task automatic check_result();
    calc_view_t want;
    if (expected_views.size() == 0) begin
      $display("result %0d: transfer with nothing expected", results_seen);
      fail_count++;
    end else begin
      want = expected_views.pop_front();
      if (res_mon.first_value !== want.first_value)
        report_mismatch("first_value", want.first_value, res_mon.first_value);
      if (res_mon.second_value !== want.second_value)
        report_mismatch("second_value", want.second_value, res_mon.second_value);
      if (res_mon.op_select !== want.op_select)
        report_mismatch("op_select", OUT_WIDTH'(want.op_select),
                        OUT_WIDTH'(res_mon.op_select));
      if (res_mon.field_select !== want.field_select)
        report_mismatch("field_select", OUT_WIDTH'(want.field_select),
                        OUT_WIDTH'(res_mon.field_select));
      if (res_mon.result_value !== want.result_value)
        report_mismatch("result_value", want.result_value, res_mon.result_value);
    end
    results_seen++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      first_acc    = '0;
      second_acc   = '0;
      cur_op       = OP_ADD;
      cur_field    = FIELD_FIRST;
      fail_count   = 0;
      results_seen = 0;
      expected_views.delete();
    end else begin
      if (res_mon.valid && res_mon.ready) check_result();
      if (key_mon.valid && key_mon.ready) apply_key(key_mon.key_code);
    end
    pending_results <= expected_views.size();
  end

endmodule

// ===== tb/sv/tb_keypad_calculator_entry.sv =====
// stimulus and verdict for the keypad calculator entry block
`timescale 1ns / 100ps

module tb_keypad_calculator_entry;
  import kce_pkg::*;

  localparam int CYCLE_LIMIT  = 2000000;
  localparam int PHASE_KEYS   = 550;
  localparam int DRAIN_CYCLES = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending_results;
  int   cycle_count = 0;
  int   src_idle_pct = 26;
  int   snk_idle_pct = 83;

  // sign wrap: 2147483648 typed into the first operand lands on the most negative value
  logic [KEY_WIDTH-1:0] opening_keys[$] = '{
    KEY_NONE, 8'hff, KEY_UP,
    KEY_DIGIT_LO + 8'd2, KEY_DIGIT_LO + 8'd1, KEY_DIGIT_LO + 8'd4,
    KEY_DIGIT_LO + 8'd7, KEY_DIGIT_LO + 8'd4, KEY_DIGIT_LO + 8'd8,
    KEY_DIGIT_LO + 8'd3, KEY_DIGIT_LO + 8'd6, KEY_DIGIT_LO + 8'd4,
    KEY_DIGIT_LO + 8'd8,
    KEY_DOWN, KEY_LEFT, KEY_RIGHT, KEY_RIGHT, KEY_RIGHT, KEY_RIGHT,
    KEY_DOWN, KEY_DOWN,
    KEY_DIGIT_LO + 8'd1, KEY_LEFT, KEY_BACK,
    KEY_DIGIT_LO + 8'd9, KEY_DIGIT_LO, KEY_RIGHT
  };

  kce_key_if    key ();
  kce_result_if result ();

  keypad_calculator_entry uut (
    .clk    (clk),
    .rst    (rst),
    .key    (key),
    .result (result)
  );

  kce_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .key_mon         (key),
    .res_mon         (result),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    result.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** keypad_calculator_entry: FAILED **");
      $finish;
    end
  end

  // mostly editing and navigation keys, with some noise over the full byte
  function automatic logic [KEY_WIDTH-1:0] pick_key();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return KEY_DIGIT_LO + KEY_WIDTH'($urandom_range(0, 9));
    if (roll < 50) return KEY_UP;
    if (roll < 60) return KEY_DOWN;
    if (roll < 70) return KEY_LEFT;
    if (roll < 80) return KEY_RIGHT;
    if (roll < 88) return KEY_BACK;
    if (roll < 92) return KEY_NONE;
    return KEY_WIDTH'($urandom_range(0, 255));
  endfunction

  task automatic send_key(input logic [KEY_WIDTH-1:0] k);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      key.valid <= 1'b0;
      @(posedge clk);
    end
    key.valid    <= 1'b1;
    key.key_code <= k;
    do @(posedge clk); while (!key.ready);
  endtask

  // hold the sender off until every outstanding result has come back
  task automatic drain_results();
    key.valid <= 1'b0;
    @(posedge clk);
    wait (pending_results == 0);
  endtask

  initial begin
    key.valid    <= 1'b0;
    key.key_code <= KEY_NONE;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (opening_keys[i]) send_key(opening_keys[i]);
    drain_results();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 26;
          snk_idle_pct = 83;
        end
        1: begin
          src_idle_pct = 83;
          snk_idle_pct = 26;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      repeat (PHASE_KEYS) send_key(pick_key());
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("** keypad_calculator_entry: PASSED **");
    end else begin
      $display("** keypad_calculator_entry: FAILED **");
    end
    $finish;
  end

endmodule
